// ===== rtl/selsort_pkg.sv =====
// selection sorter package: element width and sequencer state type
`default_nettype none
package selsort_pkg;

  localparam int VALUE_W = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_POS,
    ST_FIRST,
    ST_SCAN,
    ST_SWAP1,
    ST_SWAP2,
    ST_OUT_RD,
    ST_OUT_CAP,
    ST_OUT_WAIT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/selection_sorter.sv =====
// selection sorter: loads a set, sorts it in place by selection sort, streams it out
// load: one transaction per cycle while idle; in_ready drops once last_item is taken
// sort: for each position, the remaining elements are read one by one through the single
//   read port of the element ram, then the minimum is swapped in if it is smaller
// output: per sorted element a ram read, a capture and a handshake; the next read waits for the handshake
// reset (rst, synchronous): element count and overflow clear, ram contents stay undefined
`default_nettype none
module selection_sorter #(
  parameter int MAX_ELEMS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // load channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [selsort_pkg::VALUE_W-1:0] elem_value,
  input  wire logic                                last_item,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [selsort_pkg::VALUE_W-1:0]   sorted_value,
  output logic                                     final_result,
  output logic                                     overflow_flag
);

  localparam int IW = $clog2(MAX_ELEMS);     // element index width
  localparam int CW = $clog2(MAX_ELEMS + 1); // element count width
  localparam int VW = selsort_pkg::VALUE_W;

  selsort_pkg::state_t state, state_next;

  // control state
  logic [CW-1:0] count;        // loaded elements, also n during sort and output
  logic          overflow_seen;
  // sort datapath
  logic [IW-1:0] pos;          // position being filled
  logic [IW-1:0] scan_idx;     // index whose data is on the ram read port
  logic [IW-1:0] pick;         // index of current minimum
  logic signed [VW-1:0] pos_val;
  logic signed [VW-1:0] min_val;
  logic [IW-1:0] out_idx;      // element being emitted

  // ram port
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;
  logic signed [VW-1:0] rd_val;

  logic [IW-1:0] last_idx;
  logic          in_fire, out_fire, room, more_pos, do_swap, less;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign room     = (count < CW'(MAX_ELEMS));
  assign last_idx = IW'(count - CW'(1));
  assign rd_val   = $signed(ram_rdata);
  // a new minimum only when the candidate is strictly smaller
  assign less     = (min_val > rd_val);
  // swap only when the minimum is strictly smaller than the value in place
  assign do_swap  = (pos_val > min_val);
  // another position remains when pos + 1 < n - 1
  assign more_pos = ((CW'(pos) + CW'(2)) < count);

  selsort_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_ELEMS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      selsort_pkg::ST_LOAD: begin
        if (in_fire && last_item) begin
          // sort only when the set holds at least two elements; a single element goes straight to output
          if (room ? (count >= CW'(1)) : 1'b1) begin
            state_next = selsort_pkg::ST_POS;
          end else begin
            state_next = selsort_pkg::ST_OUT_RD;
          end
        end
      end
      selsort_pkg::ST_POS:   state_next = selsort_pkg::ST_FIRST;
      selsort_pkg::ST_FIRST: state_next = selsort_pkg::ST_SCAN;
      selsort_pkg::ST_SCAN: begin
        if (scan_idx == last_idx) begin
          state_next = selsort_pkg::ST_SWAP1;
        end
      end
      selsort_pkg::ST_SWAP1: begin
        if (do_swap) begin
          state_next = selsort_pkg::ST_SWAP2;
        end else if (more_pos) begin
          state_next = selsort_pkg::ST_POS;
        end else begin
          state_next = selsort_pkg::ST_OUT_RD;
        end
      end
      selsort_pkg::ST_SWAP2: begin
        if (more_pos) begin
          state_next = selsort_pkg::ST_POS;
        end else begin
          state_next = selsort_pkg::ST_OUT_RD;
        end
      end
      selsort_pkg::ST_OUT_RD:  state_next = selsort_pkg::ST_OUT_CAP;
      selsort_pkg::ST_OUT_CAP: state_next = selsort_pkg::ST_OUT_WAIT;
      selsort_pkg::ST_OUT_WAIT: begin
        if (out_fire) begin
          state_next = final_result ? selsort_pkg::ST_LOAD : selsort_pkg::ST_OUT_RD;
        end
      end
      default: state_next = selsort_pkg::ST_LOAD;
    endcase
  end

  // outputs: handshake and ram port
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = VW'(min_val);
    ram_raddr = pos;
    case (state)
      selsort_pkg::ST_LOAD: begin
        in_ready  = 1'b1;
        ram_we    = in_fire && room;
        ram_waddr = IW'(count);
        ram_wdata = VW'(elem_value);
      end
      selsort_pkg::ST_POS: begin
        ram_raddr = pos;
      end
      selsort_pkg::ST_FIRST: begin
        ram_raddr = pos + IW'(1);
      end
      selsort_pkg::ST_SCAN: begin
        ram_raddr = scan_idx + IW'(1);
      end
      selsort_pkg::ST_SWAP1: begin
        ram_we    = do_swap;
        ram_waddr = pos;
        ram_wdata = VW'(min_val);
      end
      selsort_pkg::ST_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = pick;
        ram_wdata = VW'(pos_val);
      end
      selsort_pkg::ST_OUT_RD: begin
        ram_raddr = out_idx;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= selsort_pkg::ST_LOAD;
      count         <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == selsort_pkg::ST_LOAD && in_fire) begin
        if (room) begin
          count <= count + CW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (state == selsort_pkg::ST_OUT_CAP) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
        // end of run: ready for the next set
        if (final_result) begin
          count         <= '0;
          overflow_seen <= 1'b0;
        end
      end
    end
  end

  // sort and output datapath
  always_ff @(posedge clk) begin
    case (state)
      selsort_pkg::ST_LOAD: begin
        pos     <= '0;
        out_idx <= '0;
      end
      selsort_pkg::ST_FIRST: begin
        // element at pos is the first candidate
        pos_val  <= rd_val;
        min_val  <= rd_val;
        pick     <= pos;
        scan_idx <= pos + IW'(1);
      end
      selsort_pkg::ST_SCAN: begin
        if (less) begin
          min_val <= rd_val;
          pick    <= scan_idx;
        end
        scan_idx <= scan_idx + IW'(1);
      end
      selsort_pkg::ST_SWAP1: begin
        if (!do_swap) begin
          pos <= pos + IW'(1);
        end
      end
      selsort_pkg::ST_SWAP2: begin
        pos <= pos + IW'(1);
      end
      selsort_pkg::ST_OUT_CAP: begin
        sorted_value  <= rd_val;
        final_result  <= (out_idx == last_idx);
        overflow_flag <= overflow_seen;
      end
      selsort_pkg::ST_OUT_WAIT: begin
        if (out_fire) begin
          out_idx <= out_idx + IW'(1);
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/selsort_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module selsort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== test/selection_sorter_tb.sv =====
// testbench for selection_sorter: random and directed sets checked against a sort predictor
`timescale 1ns / 100ps

module selection_sorter_tb;

  localparam int STORE_DEPTH  = 32;      // element store size of the block
  localparam int RANDOM_ITEMS = 420;     // random load transactions to send
  localparam int CYCLE_LIMIT  = 300000;  // watchdog, many times the slowest run
  localparam int DRAIN_CYCLES = 64;      // quiet time after the last result

  typedef logic signed [selsort_pkg::VALUE_W-1:0] elem_t;

  localparam elem_t ELEM_MAX = {1'b0, {(selsort_pkg::VALUE_W-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(selsort_pkg::VALUE_W-1){1'b0}}};

  // one sorted result transaction as it should come out of the block
  typedef struct {
    elem_t value;
    logic  is_final;
    logic  dropped;
  } sorted_beat_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  elem_t elem_value = '0;
  logic  last_item = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  elem_t sorted_value;
  logic  final_result;
  logic  overflow_flag;

  // predictor state: elements loaded so far in the current set
  elem_t        loaded_elems[$];
  logic         drop_seen;
  sorted_beat_t pending_sorted[$];

  int errors        = 0;
  int sets_sent     = 0;
  int elems_sent    = 0;
  int results_seen  = 0;
  int overflow_sets = 0;
  int random_sent   = 0;
  int burst_left    = 0;
  int cycle_count   = 0;

  selection_sorter #(
    .MAX_ELEMS(STORE_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .elem_value   (elem_value),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .final_result (final_result),
    .overflow_flag(overflow_flag)
  );

  always #5 clk = ~clk;

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_sorted.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // result side back-pressure: the stall style is drawn anew each time the low six
  // bits of the phase counter wrap, so that stalls land on first, middle and final
  // results of a set, with some stretches that never stall at all
  // ---------------------------------------------------------------------------
  int unsigned stall_style = 0;
  int unsigned stall_phase = 0;

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[5:0] == 6'd63) begin
      stall_style <= $urandom_range(0, 3);
    end
    case (stall_style)
      0: begin
        out_ready <= 1'b1;                           // never stall
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));       // coin flip
      end
      2: begin
        out_ready <= ($urandom_range(0, 5) == 0);    // mostly stalled
      end
      default: begin
        out_ready <= (stall_phase[2:0] != 3'b011);   // fixed periodic hole
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // predictor: mirrors the store on every accepted load transaction; the item
  // flagged last triggers a selection sort of what was kept
  // ---------------------------------------------------------------------------
  task automatic load_and_sort(input elem_t v, input logic last);
    elem_t        work[];
    int           n;
    int           pick;
    elem_t        tmp;
    sorted_beat_t beat;
    // store full: the element is dropped, the last flag still counts
    if (loaded_elems.size() < STORE_DEPTH) begin
      loaded_elems.push_back(v);
    end else begin
      drop_seen = 1'b1;
    end
    if (!last) begin
      return;
    end
    n = loaded_elems.size();
    work = new[n];
    foreach (loaded_elems[i]) work[i] = loaded_elems[i];
    // first smallest wins the scan, swap only on strictly smaller
    for (int pos = 0; pos + 1 < n; pos++) begin
      pick = pos;
      for (int j = pos + 1; j < n; j++) begin
        if (work[pick] > work[j]) pick = j;
      end
      if (work[pos] > work[pick]) begin
        tmp        = work[pos];
        work[pos]  = work[pick];
        work[pick] = tmp;
      end
    end
    for (int k = 0; k < n; k++) begin
      beat.value    = work[k];
      beat.is_final = (k == n - 1);
      beat.dropped  = drop_seen;
      pending_sorted.push_back(beat);
    end
    if (drop_seen) overflow_sets++;
    sets_sent++;
    loaded_elems.delete();
    drop_seen = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sender: bursts of random length separated by random gaps; valid stays high
  // from one transaction to the next inside a burst
  // ---------------------------------------------------------------------------
  task automatic send_elem(input elem_t v, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst with no gap at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid   <= 1'b1;
    elem_value <= v;
    last_item  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    elems_sent++;
    load_and_sort(v, last);
  endtask

  // random element; the flavor picks full range, a narrow band full of
  // duplicates, or values at and near the signed extremes
  function automatic elem_t pick_elem(input int flavor);
    case (flavor)
      0: begin
        return elem_t'($urandom);
      end
      1: begin
        return elem_t'($signed($urandom_range(0, 6)) - 3);
      end
      default: begin
        case ($urandom_range(0, 5))
          0: return ELEM_MAX;
          1: return ELEM_MIN;
          2: return ELEM_MAX - elem_t'($urandom_range(0, 3));
          3: return ELEM_MIN + elem_t'($urandom_range(0, 3));
          4: return elem_t'(-1);
          default: return elem_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // one whole set of random content, last flag on its final transaction
  task automatic send_random_set(input int n);
    int flavor;
    int r;
    r = $urandom_range(0, 9);
    flavor = (r < 5) ? 0 : (r < 8) ? 1 : 2;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_elem(pick_elem($urandom_range(0, 2)), (i == n - 1));
      end else begin
        send_elem(pick_elem(flavor), (i == n - 1));
      end
      random_sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // checker: every accepted result transaction is matched to the oldest
  // prediction, field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    sorted_beat_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_sorted.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: value %0d final %0b overflow %0b",
                 $time, sorted_value, final_result, overflow_flag);
      end else begin
        want = pending_sorted.pop_front();
        if (sorted_value !== want.value) begin
          errors++;
          $display("%0t: sorted_value expected %0d actual %0d", $time, want.value,
                   sorted_value);
        end
        if (final_result !== want.is_final) begin
          errors++;
          $display("%0t: final_result expected %0b actual %0b", $time, want.is_final,
                   final_result);
        end
        if (overflow_flag !== want.dropped) begin
          errors++;
          $display("%0t: overflow_flag expected %0b actual %0b", $time, want.dropped,
                   overflow_flag);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // one-element sets at both signed extremes, all bits seen at 0 and 1
  task automatic test_single_elements();
    send_elem(ELEM_MAX, 1'b1);
    send_elem(ELEM_MIN, 1'b1);
  endtask

  // extremes mixed with zero and minus one, with duplicated extremes
  task automatic test_extremes();
    send_elem(ELEM_MAX, 1'b0);
    send_elem(ELEM_MIN, 1'b0);
    send_elem(elem_t'(0), 1'b0);
    send_elem(elem_t'(-1), 1'b0);
    send_elem(ELEM_MIN, 1'b0);
    send_elem(ELEM_MAX, 1'b0);
    send_elem(elem_t'(1), 1'b1);
  endtask

  // already ascending input, then fully descending input
  task automatic test_presorted();
    send_elem(elem_t'(-3), 1'b0);
    send_elem(elem_t'(-1), 1'b0);
    send_elem(elem_t'(2), 1'b0);
    send_elem(elem_t'(5), 1'b1);
    send_elem(elem_t'(9), 1'b0);
    send_elem(elem_t'(4), 1'b0);
    send_elem(elem_t'(0), 1'b0);
    send_elem(elem_t'(-7), 1'b1);
  endtask

  // repeated values: none may be lost or duplicated by the swaps
  task automatic test_equal_elements();
    send_elem(elem_t'(5), 1'b0);
    send_elem(elem_t'(5), 1'b0);
    send_elem(elem_t'(5), 1'b0);
    send_elem(elem_t'(-2), 1'b0);
    send_elem(elem_t'(5), 1'b1);
  endtask

  // store boundary: exactly full, one over (the last item itself dropped),
  // and well over capacity
  task automatic test_store_full();
    send_random_set(STORE_DEPTH);
    send_random_set(STORE_DEPTH + 1);
    send_random_set($urandom_range(STORE_DEPTH + 2, STORE_DEPTH + 8));
  endtask

  // random sets: mostly small, some large, a few past capacity
  task automatic test_random_sets();
    int r;
    int n;
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r < 12)      n = $urandom_range(1, 8);
      else if (r < 17) n = $urandom_range(9, 20);
      else if (r < 19) n = $urandom_range(21, STORE_DEPTH);
      else             n = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
      send_random_set(n);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    drop_seen = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_single_elements();
    test_extremes();
    test_presorted();
    test_equal_elements();
    test_store_full();
    test_random_sets();

    // all load transactions accepted: let the last set drain out
    in_valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_sorted.size() != 0 || loaded_elems.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_sorted.size());
    end

    $display("covered %0d sets from %0d loaded elements, %0d of them past capacity",
             sets_sent, elems_sent, overflow_sets);
    $display("checked %0d sorted results, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/selsort_pkg.sv
rtl/selsort_ram.sv
rtl/selection_sorter.sv
test/selection_sorter_tb.sv
